[design/wcl_pkg.sv]
// Package: shared types, constants and tables for the weighted centroid locator.
package wcl_pkg;

  localparam int unsigned MaxBeaconsDefault = 16;
  localparam logic [15:0] WindowReset = 16'd15000;
  localparam logic [15:0] MapReset = 16'hFFFF;
  localparam logic [7:0] RunnerUpReset = -8'sd120;
  localparam logic [39:0] W40Max = {40{1'b1}};
  localparam logic [1:0] CfgWindow = 2'd0;
  localparam logic [1:0] CfgMapW = 2'd1;
  localparam logic [1:0] CfgMapH = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_AGE_DIV, ST_DIST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_ACC,
    ST_CHECK, ST_DIV_X, ST_DIV_Y, ST_SNAP, ST_OUT
  } state_e;

  typedef struct packed {
    logic capture;
    logic start_age;
    logic start_dist;
    logic mul1;
    logic mul2;
    logic mul3;
    logic accumulate;
    logic start_div_x;
    logic start_div_y;
    logic snap;
    logic load_out;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic usable;
    logic last;
    logic none;
  } status_t;

  function automatic logic [19:0] root_tab(input logic [4:0] r);
    logic [19:0] v;
    case (r)
      5'd0: v = 20'd65536;   5'd1: v = 20'd73533;   5'd2: v = 20'd82505;
      5'd3: v = 20'd92572;   5'd4: v = 20'd103868;  5'd5: v = 20'd116541;
      5'd6: v = 20'd130762;  5'd7: v = 20'd146717;  5'd8: v = 20'd164619;
      5'd9: v = 20'd184706;  5'd10: v = 20'd207243; 5'd11: v = 20'd232531;
      5'd12: v = 20'd260904; 5'd13: v = 20'd292739; 5'd14: v = 20'd328458;
      5'd15: v = 20'd368536; 5'd16: v = 20'd413504; 5'd17: v = 20'd463959;
      5'd18: v = 20'd520571; 5'd19: v = 20'd584090;
      default: v = 20'd0;
    endcase
    return v;
  endfunction

  // Signal weight for rssi clamped to [-128,0]; m in [12,140].
  function automatic logic [35:0] sig_weight(input logic [7:0] m);
    logic [15:0] mq;
    logic [4:0] r;
    logic [2:0] q;
    logic [19:0] t;
    logic [55:0] p;
    mq = 16'(m) * 16'd205;
    q = mq[14:12];
    r = 5'(m - 8'(q) * 8'd20);
    t = root_tab(r);
    case (q)
      3'd0: p = (56'(t) * 56'h51EB851F) >> 37;
      3'd1: p = (56'(t) * 56'hCCCCCCCD) >> 35;
      3'd2: p = 56'(t);
      3'd3: p = 56'(t) * 56'd10;
      3'd4: p = 56'(t) * 56'd100;
      3'd5: p = 56'(t) * 56'd1000;
      3'd6: p = 56'(t) * 56'd10000;
      default: p = 56'(t) * 56'd100000;
    endcase
    return 36'(p);
  endfunction

endpackage

[design/wcl_divider.sv]
// Radix-2 restoring divider: 64-bit dividend by 64-bit divisor, one bit per cycle.
module wcl_divider (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [63:0] den_i,
  output logic        done_o,
  output logic [63:0] quo_o
);
  logic [63:0] quo_q, quo_d, rem_q, rem_d;
  logic [64:0] trial;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [63:0] den_q, den_d;

  always_comb begin
    quo_d = quo_q; rem_d = rem_q; cnt_d = cnt_q; busy_d = busy_q;
    den_d = den_q; done_d = 1'b0;
    trial = {rem_q, quo_q[63]} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i; rem_d = '0; den_d = den_i; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0];
        quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = {rem_q[62:0], quo_q[63]};
        quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d; rem_q <= rem_d; den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
endmodule

[design/wcl_datapath.sv]
// Datapath: beacon weighting, saturating sums, best-signal tracking, final estimate.
module wcl_datapath #(
  parameter int unsigned MaxBeacons = wcl_pkg::MaxBeaconsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wcl_pkg::cmd_t      cmd_i,
  output wcl_pkg::status_t   status_o,
  input  logic [15:0]        window_i,
  input  logic [15:0]        map_width_i,
  input  logic [15:0]        map_height_i,
  input  logic [15:0]        beacon_x_i,
  input  logic [15:0]        beacon_y_i,
  input  logic signed [7:0]  signal_dbm_i,
  input  logic [15:0]        range_est_i,
  input  logic [8:0]         trust_i,
  input  logic [15:0]        age_ms_i,
  input  logic               ever_seen_i,
  input  logic               last_beacon_i,
  output logic [15:0]        pos_x_o,
  output logic [15:0]        pos_y_o,
  output logic [4:0]         used_count_o,
  output logic [9:0]         accuracy_tenths_o,
  output logic [1:0]         quality_o
);
  import wcl_pkg::*;

  localparam int unsigned Cap = (MaxBeacons > 31) ? 31 : MaxBeacons;

  logic [15:0] bx_q, by_q, dist_q, age_q;
  logic signed [7:0] sig_q;
  logic [8:0]  trust_q;
  logic        seen_q, last_q;
  logic [63:0] wt_q, wx_q, wy_q;
  logic [4:0]  cnt_q;
  logic signed [7:0] best_q, runner_q;
  logic [15:0] best_x_q, best_y_q;
  logic [63:0] prod_q, age_ramp_q, dist_w_q, cx_q;
  logic [15:0] px_q, py_q;
  logic [63:0] div_num, div_den, div_quo;
  logic        div_start, div_done;
  logic        usable;

  assign usable = seen_q && (age_q <= window_i) && (cnt_q < 5'(Cap));

  always_comb begin
    div_start = 1'b0; div_num = '0; div_den = 64'd1;
    if (cmd_i.start_age) begin
      div_start = 1'b1; div_num = {32'd0, age_q, 16'd0}; div_den = {48'd0, window_i};
    end else if (cmd_i.start_dist) begin
      div_start = 1'b1; div_num = 64'h1_0000_0000;
      div_den = 64'd16384 + 64'(32'(dist_q) * 32'(dist_q));
    end else if (cmd_i.start_div_x) begin
      div_start = 1'b1; div_num = wx_q; div_den = wt_q;
    end else if (cmd_i.start_div_y) begin
      div_start = 1'b1; div_num = wy_q; div_den = wt_q;
    end
  end

  wcl_divider u_div (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(div_num), .den_i(div_den),
    .done_o(div_done), .quo_o(div_quo)
  );

  logic [7:0]  m_val;
  logic [63:0] ramp;
  logic [39:0] w40;
  logic [15:0] cx16, cy16, sx, sy;
  logic signed [8:0] lead;
  logic        snap_hi, snap_mid;

  always_comb begin
    m_val = sig_q[7] ? 8'(9'(sig_q) + 9'd140) : 8'd140;
    if (window_i == 16'd0) ramp = 64'd65536;
    else if (age_ramp_q >= 64'd65536) ramp = 64'd13107;
    else if (64'd65536 - age_ramp_q < 64'd13107) ramp = 64'd13107;
    else ramp = 64'd65536 - age_ramp_q;
    w40 = (prod_q > 64'(W40Max)) ? W40Max : prod_q[39:0];
    lead = {best_q[7], best_q} - {runner_q[7], runner_q};
    snap_hi = (best_q >= -8'sd60) || ((best_q >= -8'sd70) && (lead >= 9'sd10));
    snap_mid = (best_q >= -8'sd75) || (lead >= 9'sd8);
  end

  function automatic logic [15:0] snap_fn(input logic [15:0] c, input logic [15:0] b,
                                           input logic hi, input logic mid);
    logic [17:0] s;
    logic [22:0] t;
    logic [55:0] u;
    s = 18'(c) + 18'(b) * 18'd3;
    t = 23'(c) * 23'd55 + 23'(b) * 23'd45;
    u = (56'(t) * 56'h51EB851F) >> 37;
    if (hi) return 16'(s >> 2);
    else if (mid) return 16'(u);
    return c;
  endfunction

  assign cy16 = (div_quo > 64'hFFFF) ? 16'hFFFF : div_quo[15:0];
  assign cx16 = (cx_q > 64'hFFFF) ? 16'hFFFF : cx_q[15:0];
  assign sx = snap_fn(cx16, best_x_q, snap_hi, snap_mid);
  assign sy = snap_fn(cy16, best_y_q, snap_hi, snap_mid);

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      bx_q <= beacon_x_i; by_q <= beacon_y_i; sig_q <= signal_dbm_i;
      dist_q <= range_est_i; trust_q <= trust_i; age_q <= age_ms_i;
      seen_q <= ever_seen_i; last_q <= last_beacon_i;
    end
    if (cmd_i.start_dist) age_ramp_q <= div_quo;
    if (cmd_i.mul1) begin
      dist_w_q <= div_quo;
      prod_q <= 64'((26'(trust_q) * 26'(ramp[16:0])) >> 8);
    end
    if (cmd_i.mul2) prod_q <= 64'((53'(prod_q[16:0]) * 53'(sig_weight(m_val))) >> 16);
    if (cmd_i.mul3) prod_q <= 64'((53'(prod_q[33:0]) * 53'(dist_w_q[18:0])) >> 16);
    if (cmd_i.start_div_y) cx_q <= div_quo;
    if (cmd_i.snap) begin
      px_q <= (sx > map_width_i) ? map_width_i : sx;
      py_q <= (sy > map_height_i) ? map_height_i : sy;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wt_q <= '0; wx_q <= '0; wy_q <= '0; cnt_q <= '0;
      best_q <= '0; runner_q <= RunnerUpReset; best_x_q <= '0; best_y_q <= '0;
      pos_x_o <= '0; pos_y_o <= '0; used_count_o <= '0;
      accuracy_tenths_o <= '0; quality_o <= '0;
    end else begin
      if (cmd_i.accumulate && usable) begin
        if (cnt_q == 5'd0) begin
          best_q <= sig_q; best_x_q <= bx_q; best_y_q <= by_q;
        end else if (sig_q > best_q) begin
          runner_q <= best_q; best_q <= sig_q; best_x_q <= bx_q; best_y_q <= by_q;
        end else if (sig_q > runner_q) begin
          runner_q <= sig_q;
        end
        wt_q <= sat_add(wt_q, 64'(w40));
        wx_q <= sat_add(wx_q, 64'(w40) * 64'(bx_q));
        wy_q <= sat_add(wy_q, 64'(w40) * 64'(by_q));
        cnt_q <= cnt_q + 5'd1;
      end
      if (cmd_i.load_out) begin
        if (status_o.none) begin
          pos_x_o <= '0; pos_y_o <= '0; used_count_o <= '0;
          accuracy_tenths_o <= 10'd1000; quality_o <= 2'd0;
        end else begin
          pos_x_o <= px_q; pos_y_o <= py_q; used_count_o <= cnt_q;
          if (best_q >= -8'sd65 && cnt_q >= 5'd3) begin
            accuracy_tenths_o <= 10'd15; quality_o <= 2'd2;
          end else if (cnt_q >= 5'd4) begin
            accuracy_tenths_o <= 10'd30; quality_o <= 2'd1;
          end else begin
            accuracy_tenths_o <= 10'd50; quality_o <= 2'd1;
          end
        end
      end
      if (cmd_i.clear) begin
        wt_q <= '0; wx_q <= '0; wy_q <= '0; cnt_q <= '0;
        best_q <= '0; runner_q <= RunnerUpReset; best_x_q <= '0; best_y_q <= '0;
      end
    end
  end

  assign status_o.div_done = div_done;
  assign status_o.usable   = usable;
  assign status_o.last     = last_q;
  assign status_o.none     = (cnt_q == 5'd0) || (wt_q == 64'd0);

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 5'(Cap))
    else $error("usable count above cap");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (cnt_q == 5'd0 && wt_q == 64'd0))
    else $error("set not cleared");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 5'd0) |-> (runner_q == RunnerUpReset && wt_q == 64'd0))
    else $error("empty set holds stale state");
endmodule

[design/wcl_ctrl.sv]
// Controller: weighting and accumulation per request, final division per set.
module wcl_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  wcl_pkg::status_t status_i,
  output wcl_pkg::cmd_t    cmd_o
);
  import wcl_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE; out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d; out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1; state_d = ST_AGE_DIV;
        end
      end
      ST_AGE_DIV: begin
        if (status_i.usable) begin
          cmd_o.start_age = 1'b1; state_d = ST_DIST_DIV;
        end else begin
          state_d = ST_CHECK;
        end
      end
      ST_DIST_DIV: if (status_i.div_done) begin
        cmd_o.start_dist = 1'b1; state_d = ST_MUL1;
      end
      ST_MUL1: if (status_i.div_done) begin
        cmd_o.mul1 = 1'b1; state_d = ST_MUL2;
      end
      ST_MUL2: begin cmd_o.mul2 = 1'b1; state_d = ST_MUL3; end
      ST_MUL3: begin cmd_o.mul3 = 1'b1; state_d = ST_ACC; end
      ST_ACC: begin cmd_o.accumulate = 1'b1; state_d = ST_CHECK; end
      ST_CHECK: begin
        if (!status_i.last) state_d = ST_IDLE;
        else if (status_i.none) state_d = ST_OUT;
        else begin
          cmd_o.start_div_x = 1'b1; state_d = ST_DIV_X;
        end
      end
      ST_DIV_X: if (status_i.div_done) begin
        cmd_o.start_div_y = 1'b1; state_d = ST_DIV_Y;
      end
      ST_DIV_Y: if (status_i.div_done) state_d = ST_SNAP;
      ST_SNAP: begin cmd_o.snap = 1'b1; state_d = ST_OUT; end
      ST_OUT: if (!out_valid_q || out_ready_i) begin
        cmd_o.load_out = 1'b1; cmd_o.clear = 1'b1;
        out_valid_d = 1'b1; state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_o)
    else $error("result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_ready_o && in_valid_i) |=> (state_q == ST_AGE_DIV))
    else $error("request not started");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.start_age, cmd_o.start_dist, cmd_o.start_div_x, cmd_o.start_div_y}))
    else $error("divider started twice");
endmodule

[design/weighted_centroid_locator.sv]
// Top level: RSSI-weighted centroid locator with config registers.
// Usage:
//   Input channel in_valid_i/in_ready_o carries one beacon observation per
//   request; last_beacon_i marks the final beacon of a scan set.
//   Output channel out_valid_o/out_ready_i carries one position per set.
//   Config: cfg_we_i, cfg_idx_i, cfg_data_i write window and map limits.
// Sequencing:
//   A usable beacon runs two divisions (age ramp, distance weight) on one
//   shared bit-serial divider before the next request can be taken; an
//   unusable beacon skips them. The last beacon of a set then adds the x
//   and y centroid divisions on the same divider, the snap and the output
//   load; with no usable weight it adds only the output load.
// Reset: config returns to window 15000 and full map; running sums clear.
// Stall: the result sits in an output register; the block keeps taking
//   requests, and only a second result waits until the first is taken.
module weighted_centroid_locator #(
  parameter int unsigned MaxBeacons = wcl_pkg::MaxBeaconsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [15:0]       beacon_x_i,
  input  logic [15:0]       beacon_y_i,
  input  logic signed [7:0] signal_dbm_i,
  input  logic [15:0]       range_est_i,
  input  logic [8:0]        trust_i,
  input  logic [15:0]       age_ms_i,
  input  logic              ever_seen_i,
  input  logic              last_beacon_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [15:0]       pos_x_o,
  output logic [15:0]       pos_y_o,
  output logic [4:0]        used_count_o,
  output logic [9:0]        accuracy_tenths_o,
  output logic [1:0]        quality_o
);
  import wcl_pkg::*;

  logic [15:0] window_q, map_w_q, map_h_q;
  cmd_t    cmd;
  status_t status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WindowReset; map_w_q <= MapReset; map_h_q <= MapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgWindow: window_q <= cfg_data_i;
        CfgMapW:   map_w_q  <= cfg_data_i;
        CfgMapH:   map_h_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  wcl_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .status_i(status), .cmd_o(cmd)
  );

  wcl_datapath #(.MaxBeacons(MaxBeacons)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .status_o(status),
    .window_i(window_q), .map_width_i(map_w_q), .map_height_i(map_h_q),
    .beacon_x_i, .beacon_y_i, .signal_dbm_i, .range_est_i, .trust_i,
    .age_ms_i, .ever_seen_i, .last_beacon_i,
    .pos_x_o, .pos_y_o, .used_count_o, .accuracy_tenths_o, .quality_o
  );
endmodule

[bench/tb_top.sv]
// Testbench for weighted_centroid_locator: scoreboard with an internal predictor, random bursts.
`timescale 1ns / 100ps

module tb_top;
  import wcl_pkg::*;

  typedef struct {
    logic [15:0]       bx;
    logic [15:0]       by;
    logic signed [7:0] dbm;
    logic [15:0]       rng;
    logic [8:0]        trust;
    logic [15:0]       age;
    logic              seen;
    logic              last;
  } beacon_t;

  typedef struct {
    logic [15:0] px;
    logic [15:0] py;
    logic [4:0]  used;
    logic [9:0]  acc;
    logic [1:0]  qual;
  } fix_t;

  class centroid_scoreboard;
    logic [15:0] window, map_w, map_h;
    logic [63:0] wsum, xsum, ysum;
    int          used, top_dbm, second_dbm;
    logic [15:0] top_x, top_y;
    fix_t        pending_fixes[$];
    int          errors;

    function void clear_scan();
      wsum = 0; xsum = 0; ysum = 0; used = 0;
      top_dbm = 0; top_x = 0; top_y = 0; second_dbm = -120;
    endfunction

    function void reset_all();
      window = WindowReset; map_w = MapReset; map_h = MapReset;
      clear_scan();
    endfunction

    function logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    function logic [63:0] rssi_gain(logic signed [7:0] dbm);
      logic [19:0] roots [20];
      logic [63:0] g;
      int m;
      roots = '{65536, 73533, 82505, 92572, 103868, 116541, 130762, 146717,
                164619, 184706, 207243, 232531, 260904, 292739, 328458,
                368536, 413504, 463959, 520571, 584090};
      m = (dbm > 0 ? 0 : int'(dbm)) + 140;
      g = 64'(roots[m % 20]);
      for (int k = 0; k < (m / 20) % 8; k++) g = g * 10;
      return g / 100;
    endfunction

    function logic [63:0] beacon_weight(beacon_t b);
      logic [63:0] ramp, drop, dw, p;
      ramp = 65536;
      if (window != 0) begin
        drop = {32'd0, b.age, 16'd0} / 64'(window);
        ramp = (drop >= 65536) ? 0 : 65536 - drop;
        if (ramp < 13107) ramp = 13107;
      end
      dw = 64'h1_0000_0000 / (64'd16384 + 64'(b.rng) * 64'(b.rng));
      p = (64'(b.trust) * ramp) >> 8;
      p = (p * rssi_gain(b.dbm)) >> 16;
      p = (p * dw) >> 16;
      return (p > 64'(W40Max)) ? 64'(W40Max) : p;
    endfunction

    function void note_request(beacon_t b);
      logic [63:0] w, cx, cy;
      int lead;
      fix_t f;
      if (b.seen && b.age <= window && used < 16) begin
        if (used == 0) begin
          top_dbm = b.dbm; top_x = b.bx; top_y = b.by;
        end else if (b.dbm > top_dbm) begin
          second_dbm = top_dbm;
          top_dbm = b.dbm; top_x = b.bx; top_y = b.by;
        end else if (b.dbm > second_dbm) begin
          second_dbm = b.dbm;
        end
        w = beacon_weight(b);
        wsum = sat_sum(wsum, w);
        xsum = sat_sum(xsum, w * 64'(b.bx));
        ysum = sat_sum(ysum, w * 64'(b.by));
        used++;
      end
      if (!b.last) return;
      if (used == 0 || wsum == 0) begin
        f = '{16'd0, 16'd0, 5'd0, 10'd1000, 2'd0};
      end else begin
        cx = xsum / wsum;
        cy = ysum / wsum;
        if (cx > 64'hFFFF) cx = 64'hFFFF;
        if (cy > 64'hFFFF) cy = 64'hFFFF;
        lead = top_dbm - second_dbm;
        if (top_dbm >= -60 || (top_dbm >= -70 && lead >= 10)) begin
          cx = (cx + 3 * 64'(top_x)) / 4;
          cy = (cy + 3 * 64'(top_y)) / 4;
        end else if (top_dbm >= -75 || lead >= 8) begin
          cx = (55 * cx + 45 * 64'(top_x)) / 100;
          cy = (55 * cy + 45 * 64'(top_y)) / 100;
        end
        if (cx > 64'(map_w)) cx = 64'(map_w);
        if (cy > 64'(map_h)) cy = 64'(map_h);
        f.px = cx[15:0];
        f.py = cy[15:0];
        f.used = 5'(used);
        if (top_dbm >= -65 && used >= 3) begin
          f.acc = 15; f.qual = 2;
        end else if (used >= 4) begin
          f.acc = 30; f.qual = 1;
        end else begin
          f.acc = 50; f.qual = 1;
        end
      end
      pending_fixes.insert(pending_fixes.size(), f);
      clear_scan();
    endfunction

    task report(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(fix_t r);
      fix_t e;
      if (pending_fixes.size() == 0) begin
        report("unexpected result, pos_x", r.px, -1);
        return;
      end
      e = pending_fixes[0];
      pending_fixes.delete(0);
      if (r.px !== e.px) report("pos_x", r.px, e.px);
      if (r.py !== e.py) report("pos_y", r.py, e.py);
      if (r.used !== e.used) report("used_count", r.used, e.used);
      if (r.acc !== e.acc) report("accuracy_tenths", r.acc, e.acc);
      if (r.qual !== e.qual) report("quality", r.qual, e.qual);
    endtask
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [1:0] cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic in_valid_i, in_ready_o;
  logic [15:0] beacon_x_i, beacon_y_i, range_est_i, age_ms_i;
  logic signed [7:0] signal_dbm_i;
  logic [8:0] trust_i;
  logic ever_seen_i, last_beacon_i;
  logic out_valid_o, out_ready_i;
  logic [15:0] pos_x_o, pos_y_o;
  logic [4:0] used_count_o;
  logic [9:0] accuracy_tenths_o;
  logic [1:0] quality_o;

  centroid_scoreboard sb;
  int burst_left;
  int quiet_cycles = 0;
  int tick = 0;

  weighted_centroid_locator u_dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin
    tick <= tick + 1;
    case (tick[10:9])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= (tick % 3 == 0);
      2'd2: out_ready_i <= ($urandom_range(0, 3) != 0);
      default: out_ready_i <= tick[4];
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i)
        sb.check_result('{pos_x_o, pos_y_o, used_count_o, accuracy_tenths_o, quality_o});
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= 5000) begin
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  task send_beacon(beacon_t b);
    if (burst_left == 0) begin
      in_valid_i = 0;
      repeat ($urandom_range(0, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 8);
    end
    burst_left--;
    {beacon_x_i, beacon_y_i, signal_dbm_i, range_est_i} = {b.bx, b.by, b.dbm, b.rng};
    {trust_i, age_ms_i, ever_seen_i, last_beacon_i} = {b.trust, b.age, b.seen, b.last};
    in_valid_i = 1;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_request(b);
    @(negedge clk_i);
  endtask

  task drain();
    in_valid_i = 0;
    while (sb.pending_fixes.size() > 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  task write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we_i = 1; cfg_idx_i = idx; cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 0;
    if (idx == CfgWindow) sb.window = val;
    else if (idx == CfgMapW) sb.map_w = val;
    else sb.map_h = val;
  endtask

  function beacon_t make_beacon(logic last);
    beacon_t b;
    b.bx = 16'($urandom); b.by = 16'($urandom); b.dbm = 8'($urandom);
    b.rng = 16'($urandom); b.trust = 9'($urandom); b.age = 16'($urandom);
    b.seen = 1'($urandom); b.last = last;
    if ($urandom_range(0, 99) < 85) begin
      b.seen = 1;
      b.age = 16'($urandom_range(0, sb.window));
      b.trust = $urandom_range(0, 9) == 0 ? 9'($urandom) : 9'($urandom_range(1, 256));
      b.dbm = $urandom_range(0, 4) == 0 ? 8'($urandom)
                                        : 8'(-int'($urandom_range(30, 105)));
      if ($urandom_range(0, 3) != 0) b.rng = 16'($urandom_range(0, 3000));
    end
    return b;
  endfunction

  task random_sets(int items);
    int n;
    while (items > 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) send_beacon(make_beacon(i == n - 1));
      items -= n;
    end
  endtask

  initial begin
    beacon_t b;
    logic [15:0] phase_cfg [5][3];
    sb = new();
    sb.reset_all();
    sb.errors = 0;
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = CfgWindow; cfg_data_i = 0;
    in_valid_i = 0;
    {beacon_x_i, beacon_y_i, signal_dbm_i, range_est_i} = '0;
    {trust_i, age_ms_i, ever_seen_i, last_beacon_i} = '0;
    burst_left = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    send_beacon('{16'd0, 16'd0, 8'sd0, 16'd0, 9'd256, 16'd0, 1'b1, 1'b1});
    send_beacon('{16'hFFFF, 16'hFFFF, 8'sh80, 16'hFFFF, 9'd511, 16'd15000, 1'b1, 1'b0});
    send_beacon('{16'd1234, 16'd4321, 8'sd127, 16'd1, 9'd256, 16'd0, 1'b1, 1'b0});
    send_beacon('{16'd500, 16'd600, -8'sd40, 16'd10, 9'd256, 16'd0, 1'b0, 1'b0});
    send_beacon('{16'd700, 16'd800, -8'sd40, 16'd10, 9'd256, 16'd15001, 1'b1, 1'b1});
    send_beacon('{16'd100, 16'd100, -8'sd50, 16'd100, 9'd0, 16'd5, 1'b1, 1'b1});
    send_beacon('{16'd100, 16'd100, -8'sd50, 16'd100, 9'd256, 16'd5, 1'b0, 1'b1});
    for (int i = 0; i < 18; i++) begin
      b = '{16'(i * 3000), 16'(65535 - i * 2000), 8'(-90 + 3 * i), 16'(i * 64),
            9'(16 * i), 16'(i * 800), 1'b1, i == 17};
      send_beacon(b);
    end
    drain();

    phase_cfg = '{'{16'd0, 16'hFFFF, 16'hFFFF}, '{16'hFFFF, 16'd0, 16'd0},
                  '{16'd1, 16'd2000, 16'd3000}, '{16'd500, 16'd40000, 16'hFFFF},
                  '{16'd15000, 16'hFFFF, 16'hFFFF}};
    random_sets(150);
    for (int p = 0; p < 5; p++) begin
      drain();
      write_reg(CfgWindow, phase_cfg[p][0]);
      write_reg(CfgMapW, phase_cfg[p][1]);
      write_reg(CfgMapH, phase_cfg[p][2]);
      random_sets(150);
    end
    drain();

    if (sb.errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

endmodule

[weighted_centroid_locator.f]
design/wcl_pkg.sv
design/wcl_divider.sv
design/wcl_datapath.sv
design/wcl_ctrl.sv
design/weighted_centroid_locator.sv
bench/tb_top.sv
